// ----- sv/bres_pkg.sv -----
// Package for the Bresenham line rasteriser.
// Holds the field widths, the item kind codes and the point record type.
// No dependencies.
package bres_pkg;

    // Field widths.
    localparam int COORD_W   = 16;
    localparam int COLOUR_W  = 8;
    localparam int ERR_W     = 18;
    localparam int ADDR_W    = 16;

    // Stream payload widths.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    // Bit positions inside m_tuser.
    localparam int USER_VALID_BIT = 0;
    localparam int USER_WE_BIT    = 1;

    // Item kinds carried on s_tuser.
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // One rasterised point between the stepping stage and the output stage.
    typedef struct packed {
        logic                is_point;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [COLOUR_W-1:0] colour;
        logic                is_last;
    } point_t;

endpackage

// ----- sv/bresenham_line_rasterizer_top.sv -----
// Top level of the Bresenham line rasteriser: stepping stage and output stage.
// Depends on bres_pkg.
//
// Channel   Direction  Beat contents
// s_        in         tuser: kind; tdata: start_x, start_y, end_x, end_y, colour
// m_        out        tuser: point_valid, write_enable; tlast: last;
//                      tdata: pixel_address, point_x, point_y, pixel_colour
//
// Every input transaction yields exactly one output transaction, via the point register
// and then the output register. One transaction is taken per clock while m_tready stays
// high; the rate is set by the error step (19-bit subtract and add, two compares) in the
// stepping stage. The address multiply by the screen width sits in the second stage.
// aresetn is synchronous and active low; both stages come out of reset empty.
// A stall on m_tready holds the output register; s_tready falls in the same cycle
// only when the point register is full as well, so one more transaction is taken.
module bresenham_line_rasterizer_top #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata, from bit 0 up: start_x[15:0], start_y[15:0], end_x[15:0], end_y[15:0],
    // colour[7:0].
    input  logic [bres_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: kind (0 start, 1 advance).
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata, from bit 0 up: pixel_address[15:0], point_x[15:0], point_y[15:0],
    // pixel_colour[7:0].
    output logic [bres_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser, from bit 0 up: point_valid, write_enable.
    output logic [bres_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);

    localparam int CW    = bres_pkg::COORD_W;
    localparam int EW    = bres_pkg::ERR_W;
    localparam int WW    = $clog2(SCREEN_WIDTH + 1);
    localparam int PW    = CW + WW;
    localparam logic [CW:0] WIDTH_LIM  = (CW+1)'(SCREEN_WIDTH);
    localparam logic [CW:0] HEIGHT_LIM = (CW+1)'(SCREEN_HEIGHT);

    // Line state.
    logic                            active_reg, active_next;
    logic [CW-1:0]                   cur_col_reg, cur_col_next;
    logic [CW-1:0]                   cur_row_reg, cur_row_next;
    logic [CW-1:0]                   tgt_col_reg, tgt_col_next;
    logic [CW-1:0]                   tgt_row_reg, tgt_row_next;
    logic [CW-1:0]                   dcol_reg, dcol_next;
    logic [CW-1:0]                   drow_reg, drow_next;
    logic                            neg_col_reg, neg_col_next;
    logic                            neg_row_reg, neg_row_next;
    logic signed [EW-1:0]            err_reg, err_next;
    logic [bres_pkg::COLOUR_W-1:0]   colour_reg, colour_next;

    // Pipeline registers.
    logic                            pt_valid_reg;
    bres_pkg::point_t                pt_reg, pt_next;
    logic                            m_valid_reg;
    logic [bres_pkg::M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [bres_pkg::M_TUSER_W-1:0]  m_user_reg, m_user_next;
    logic                            m_last_reg, m_last_next;

    // Input field views.
    logic [CW-1:0]                   in_sx, in_sy, in_ex, in_ey;
    logic [bres_pkg::COLOUR_W-1:0]   in_colour;

    // Stepping signals.
    logic signed [EW:0]              twice, err_wide, neg_drow, dcol_s, drow_s;
    logic                            step_col, step_row;
    logic [CW-1:0]                   start_dcol, start_drow;

    // Output stage signals.
    logic                            on_screen;
    logic [PW-1:0]                   row_prod;
    logic [bres_pkg::ADDR_W-1:0]     addr;

    // Handshake.
    logic                            out_load, pt_load, s_accept;

    assign out_load = !m_valid_reg || m_tready;
    assign pt_load  = !pt_valid_reg || out_load;
    assign s_tready = pt_load;
    assign s_accept = s_tvalid && s_tready;

    assign in_sx     = s_tdata[CW-1:0];
    assign in_sy     = s_tdata[2*CW-1:CW];
    assign in_ex     = s_tdata[3*CW-1:2*CW];
    assign in_ey     = s_tdata[4*CW-1:3*CW];
    assign in_colour = s_tdata[4*CW+bres_pkg::COLOUR_W-1:4*CW];

    // Error step terms for an advance.
    assign twice    = {err_reg, 1'b0};
    assign dcol_s   = signed'({3'b000, dcol_reg});
    assign drow_s   = signed'({3'b000, drow_reg});
    assign neg_drow = -drow_s;
    assign step_col = twice > neg_drow;
    assign step_row = twice < dcol_s;
    assign err_wide = {err_reg[EW-1], err_reg} - (step_col ? drow_s : '0)
                      + (step_row ? dcol_s : '0);

    assign start_dcol = (in_ex > in_sx) ? in_ex - in_sx : in_sx - in_ex;
    assign start_drow = (in_ey > in_sy) ? in_ey - in_sy : in_sy - in_ey;

    // Next line state and the point produced by the accepted transaction.
    always_comb begin
        active_next  = active_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        tgt_col_next = tgt_col_reg;
        tgt_row_next = tgt_row_reg;
        dcol_next    = dcol_reg;
        drow_next    = drow_reg;
        neg_col_next = neg_col_reg;
        neg_row_next = neg_row_reg;
        err_next     = err_reg;
        colour_next  = colour_reg;
        pt_next      = '0;
        if (s_tuser == bres_pkg::KIND_START) begin
            cur_col_next = in_sx;
            cur_row_next = in_sy;
            tgt_col_next = in_ex;
            tgt_row_next = in_ey;
            dcol_next    = start_dcol;
            drow_next    = start_drow;
            neg_col_next = !(in_sx < in_ex);
            neg_row_next = !(in_sy < in_ey);
            err_next     = signed'({2'b00, start_dcol}) - signed'({2'b00, start_drow});
            colour_next  = in_colour;
        end else if (active_reg) begin
            if (step_col) begin
                cur_col_next = neg_col_reg ? cur_col_reg - 1'b1 : cur_col_reg + 1'b1;
            end
            if (step_row) begin
                cur_row_next = neg_row_reg ? cur_row_reg - 1'b1 : cur_row_reg + 1'b1;
            end
            err_next = err_wide[EW-1:0];
        end
        if (s_tuser == bres_pkg::KIND_START || active_reg) begin
            pt_next.is_point = 1'b1;
            pt_next.col      = cur_col_next;
            pt_next.row      = cur_row_next;
            pt_next.colour   = colour_next;
            pt_next.is_last  = (cur_col_next == tgt_col_next) &&
                               (cur_row_next == tgt_row_next);
            active_next      = !pt_next.is_last;
        end
    end

    // Line state and point register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            pt_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                active_reg <= active_next;
            end
            if (pt_load) begin
                pt_valid_reg <= s_accept;
            end
        end
        if (s_accept) begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            tgt_col_reg <= tgt_col_next;
            tgt_row_reg <= tgt_row_next;
            dcol_reg    <= dcol_next;
            drow_reg    <= drow_next;
            neg_col_reg <= neg_col_next;
            neg_row_reg <= neg_row_next;
            err_reg     <= err_next;
            colour_reg  <= colour_next;
            pt_reg      <= pt_next;
        end
    end

    // Clipping and framebuffer address for the registered point.
    assign on_screen = pt_reg.is_point && ({1'b0, pt_reg.col} < WIDTH_LIM) &&
                       ({1'b0, pt_reg.row} < HEIGHT_LIM);
    assign row_prod  = pt_reg.row * WW'(SCREEN_WIDTH);
    assign addr      = on_screen ? row_prod[bres_pkg::ADDR_W-1:0] + pt_reg.col : '0;

    always_comb begin
        m_data_next = {pt_reg.colour, pt_reg.row, pt_reg.col, addr};
        m_user_next = '0;
        m_user_next[bres_pkg::USER_VALID_BIT] = pt_reg.is_point;
        m_user_next[bres_pkg::USER_WE_BIT]    = on_screen;
        m_last_next = pt_reg.is_last;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= pt_valid_reg;
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- sv/bres_checker.sv -----
// Port-level checker for the Bresenham line rasteriser, bound to the top level.
// Depends on bres_pkg and bresenham_line_rasterizer_top.
module bres_checker #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bres_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [bres_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            m_tlast
);

    localparam int CW = bres_pkg::COORD_W;

    // A stalled output transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
    else $error("output transaction changed while stalled");

    // The output stage is empty in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
    else $error("output valid straight after reset");

    // An idle advance returns an all-zero result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[bres_pkg::USER_VALID_BIT] |->
        m_tdata == '0 && !m_tlast && !m_tuser[bres_pkg::USER_WE_BIT])
    else $error("idle result carries data");

    // A written point lies on the screen; a clipped point has a zero address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[bres_pkg::USER_WE_BIT] |->
        m_tuser[bres_pkg::USER_VALID_BIT]
        && ({1'b0, m_tdata[2*CW-1:CW]} < (CW+1)'(SCREEN_WIDTH))
        && ({1'b0, m_tdata[3*CW-1:2*CW]} < (CW+1)'(SCREEN_HEIGHT)))
    else $error("write enable on an off-screen point");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[bres_pkg::USER_WE_BIT] |-> m_tdata[CW-1:0] == '0)
    else $error("clipped point has a non-zero address");

endmodule

bind bresenham_line_rasterizer_top bres_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_bres_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
